/* rtl/core/msd_pkg.sv */
// Package for the moving standard deviation block: widths, sizes and the
// status struct that the window unit hands to the top level.
// Depends on nothing; every other file in rtl/core uses it.
`default_nettype none

package msd_pkg;

  // Window store depth and the sample bits that take part in the arithmetic.
  localparam int unsigned MaxWindow  = 256;
  localparam int unsigned SampleBits = 24;

  // Fixed port widths.
  localparam int unsigned SampleW  = 24;
  localparam int unsigned DevBits  = 23;

  localparam int unsigned AddrBits = $clog2(MaxWindow);
  localparam int unsigned LenBits  = AddrBits + 1;
  localparam int unsigned LenReset = 21;

  // Running sums hold up to MaxWindow samples and squares without overflow.
  localparam int unsigned SumBits  = SampleBits + AddrBits;
  localparam int unsigned ProdBits = 2 * SampleBits;
  localparam int unsigned SqBits   = ProdBits + AddrBits;

  // Variance numerator, the squared length, and the root.
  localparam int unsigned WideBits = 2 * SumBits;
  localparam int unsigned NnBits   = 2 * AddrBits + 1;
  localparam int unsigned RootBits = WideBits / 2;

  // The divider retires two quotient bits a cycle, the root one bit.
  localparam int unsigned DivSteps    = WideBits / 2;
  localparam int unsigned DivCntBits  = $clog2(DivSteps);
  localparam int unsigned RootSteps   = RootBits;
  localparam int unsigned RootCntBits = $clog2(RootSteps);

  typedef struct packed {
    logic done;
    logic full;
  } win_stat_t;

endpackage

`default_nettype wire

/* rtl/core/msd_if.sv */
// Valid/ready channel interfaces for the sample requests and the results.
// Depends on msd_pkg for the payload widths.
`default_nettype none

interface msd_in_if;
  logic                        valid;
  logic                        ready;
  logic [msd_pkg::SampleW-1:0] sample;
  logic                        restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface msd_out_if;
  logic                        valid;
  logic                        ready;
  logic [msd_pkg::DevBits-1:0] deviation;

  modport source (output valid, output deviation, input ready);
  modport sink   (input valid, input deviation, output ready);
endinterface

`default_nettype wire

/* rtl/core/moving_standard_deviation.sv */
// Top level of the moving standard deviation block: length register,
// control sequencer and output register. Depends on msd_pkg, msd_if,
// msd_window, msd_divider and msd_isqrt.
`default_nettype none

// Each sample request updates a circular window of the last N samples held in
// a 256-entry single-port store, with running sum and sum of squares, and once
// N samples are held it returns floor(sqrt((N*sumsq - sum^2) / N^2)), the
// population deviation as an unsigned integer (Q23.0) in the units of the
// samples. Before the window is full a request gives no result. One request is
// worked at a time; a request that yields a result passes through the store
// read-modify-write and the sums, the products and the difference, the divider
// (start pulse, load and 32 steps of two quotient bits), the square root
// (load and 32 steps of one bit) and the idle state in which the next request
// is taken; the divider and root set the rate. A request that yields no result
// returns to idle after the window update. A finished result waits in an output
// register while the next request is taken; if that register is still full,
// the result is held and no request is taken. Writing the length register (0
// acts as 1, above 256 acts as 256) or setting restart empties the window; the
// store needs no clearing after reset: a slot is read only after being written.
module moving_standard_deviation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msd_pkg::LenBits-1:0]  cfg_wdata_i,
  msd_in_if.sink                       in_i,
  msd_out_if.source                    out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_MUL,
    S_DIFF,
    S_DIV,
    S_ROOT,
    S_OUT
  } state_e;

  state_e                         state_q;
  logic [msd_pkg::LenBits-1:0]    len_q;
  logic [msd_pkg::LenBits-1:0]    eff_len;
  logic [msd_pkg::WideBits-1:0]   a_q, b_q, d_q;
  logic [msd_pkg::NnBits-1:0]     nn_q;
  logic                           div_start_q;
  logic                           out_valid_q;
  logic [msd_pkg::DevBits-1:0]    dev_q;

  logic                           accept;
  logic                           slot_free;
  logic                           load_out;
  logic [msd_pkg::SqBits+msd_pkg::LenBits-1:0] a_full;

  logic [msd_pkg::SumBits-1:0]    sum;
  logic [msd_pkg::SqBits-1:0]     sumsq;
  msd_pkg::win_stat_t             win_stat;
  logic                           div_done;
  logic [msd_pkg::WideBits-1:0]   quotient;
  logic                           root_done;
  logic [msd_pkg::RootBits-1:0]   root;

  always_comb begin
    if (len_q == '0) begin
      eff_len = msd_pkg::LenBits'(1);
    end else if (len_q > msd_pkg::LenBits'(msd_pkg::MaxWindow)) begin
      eff_len = msd_pkg::LenBits'(msd_pkg::MaxWindow);
    end else begin
      eff_len = len_q;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign load_out   = slot_free &&
                      ((state_q == S_ROOT && root_done) || state_q == S_OUT);
  assign a_full     = (msd_pkg::SqBits + msd_pkg::LenBits)'(eff_len) *
                      (msd_pkg::SqBits + msd_pkg::LenBits)'(sumsq);

  msd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we_i),
    .start_i   (accept),
    .sample_i  (in_i.sample),
    .restart_i (in_i.restart),
    .len_i     (eff_len),
    .sum_o     (sum),
    .sumsq_o   (sumsq),
    .stat_o    (win_stat)
  );

  msd_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (d_q),
    .divisor_i  (nn_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  msd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_done),
    .radicand_i (quotient),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= msd_pkg::LenBits'(msd_pkg::LenReset);
      a_q         <= '0;
      b_q         <= '0;
      d_q         <= '0;
      nn_q        <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      dev_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
        dev_q       <= root[msd_pkg::DevBits-1:0];
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_stat.done) begin
            state_q <= win_stat.full ? S_MUL : S_IDLE;
          end
        end
        S_MUL: begin
          a_q     <= a_full[msd_pkg::WideBits-1:0];
          b_q     <= msd_pkg::WideBits'(sum) * msd_pkg::WideBits'(sum);
          nn_q    <= msd_pkg::NnBits'(eff_len) * msd_pkg::NnBits'(eff_len);
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          // Clamp at zero in case the numerator rounds below the square.
          d_q         <= (a_q >= b_q) ? (a_q - b_q) : '0;
          div_start_q <= 1'b1;
          state_q     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state_q <= slot_free ? S_IDLE : S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.deviation = dev_q;

`ifndef SYNTHESIS
  a_win_done_in_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_stat.done |-> state_q == S_WIN)
    else $error("window update finished outside the window wait");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide wait");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == S_ROOT)
    else $error("square root finished outside the root wait");

  a_one_request_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("a second request was taken while one is in progress");
`endif

endmodule

`default_nettype wire

/* rtl/core/msd_window.sv */
// Window unit: the sample store memory, write pointer, fill count and the
// running sum and sum of squares, updated by read-modify-write per sample.
// Depends on msd_pkg.
`default_nettype none

module msd_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          start_i,
  input  logic [msd_pkg::SampleW-1:0]   sample_i,
  input  logic                          restart_i,
  input  logic [msd_pkg::LenBits-1:0]   len_i,
  output logic [msd_pkg::SumBits-1:0]   sum_o,
  output logic [msd_pkg::SqBits-1:0]    sumsq_o,
  output msd_pkg::win_stat_t            stat_o
);

  typedef enum logic [2:0] {
    W_IDLE,
    W_READ,
    W_OLD,
    W_SUBSQ,
    W_ADDSQ
  } wstate_e;

  wstate_e                          state_q;
  logic [msd_pkg::SampleBits-1:0]   x_q;
  logic [msd_pkg::AddrBits-1:0]     wp_q;
  logic [msd_pkg::LenBits-1:0]      fill_q;
  logic [msd_pkg::SumBits-1:0]      sum_q;
  logic [msd_pkg::SqBits-1:0]       sumsq_q;
  logic [msd_pkg::ProdBits-1:0]     prod_q;
  logic                             done_q;

  logic [msd_pkg::SampleBits-1:0]   mem_q [msd_pkg::MaxWindow];
  logic [msd_pkg::SampleBits-1:0]   rd_data_q;

  logic [msd_pkg::AddrBits-1:0]     old_addr;
  logic                             take_old;
  logic [msd_pkg::SampleBits-1:0]   old_val;

  // The oldest sample sits len slots behind the write pointer; a full-size
  // window wraps onto the write slot itself, which is read before it is written.
  assign old_addr = wp_q - len_i[msd_pkg::AddrBits-1:0];
  assign take_old = (fill_q >= len_i);
  assign old_val  = take_old ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      x_q     <= '0;
      wp_q    <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      prod_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (clear_i) begin
        state_q <= W_IDLE;
        wp_q    <= '0;
        fill_q  <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
      end else begin
        case (state_q)
          W_IDLE: begin
            if (start_i) begin
              x_q <= sample_i[msd_pkg::SampleBits-1:0];
              if (restart_i) begin
                wp_q    <= '0;
                fill_q  <= '0;
                sum_q   <= '0;
                sumsq_q <= '0;
              end
              state_q <= W_READ;
            end
          end
          W_READ: begin
            state_q <= W_OLD;
          end
          W_OLD: begin
            prod_q <= msd_pkg::ProdBits'(old_val) * msd_pkg::ProdBits'(old_val);
            sum_q  <= sum_q - msd_pkg::SumBits'(old_val) + msd_pkg::SumBits'(x_q);
            wp_q   <= wp_q + 1'b1;
            if (!take_old) begin
              fill_q <= fill_q + 1'b1;
            end
            state_q <= W_SUBSQ;
          end
          W_SUBSQ: begin
            sumsq_q <= sumsq_q - msd_pkg::SqBits'(prod_q);
            prod_q  <= msd_pkg::ProdBits'(x_q) * msd_pkg::ProdBits'(x_q);
            state_q <= W_ADDSQ;
          end
          W_ADDSQ: begin
            sumsq_q <= sumsq_q + msd_pkg::SqBits'(prod_q);
            done_q  <= 1'b1;
            state_q <= W_IDLE;
          end
          default: begin
            state_q <= W_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == W_OLD) begin
      mem_q[wp_q] <= x_q;
    end
    if (state_q == W_READ) begin
      rd_data_q <= mem_q[old_addr];
    end
  end

  assign sum_o       = sum_q;
  assign sumsq_o     = sumsq_q;
  assign stat_o.done = done_q;
  assign stat_o.full = (fill_q >= len_i);

endmodule

`default_nettype wire

/* rtl/core/msd_divider.sv */
// Restoring divider for the variance: divides the wide numerator by the
// squared window length, two quotient bits per cycle.
// Depends on msd_pkg.
`default_nettype none

module msd_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msd_pkg::WideBits-1:0]  dividend_i,
  input  logic [msd_pkg::NnBits-1:0]    divisor_i,
  output logic                          done_o,
  output logic [msd_pkg::WideBits-1:0]  quotient_o
);

  logic [msd_pkg::WideBits-1:0]   dv_q;
  logic [msd_pkg::NnBits-1:0]     dsr_q;
  logic [msd_pkg::NnBits-1:0]     rem_q;
  logic [msd_pkg::DivCntBits-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  logic [msd_pkg::NnBits:0]       t1, t2, dsr_ext;
  logic [msd_pkg::NnBits-1:0]     r1, r2;
  logic                           q1, q2;

  // The dividend register shifts left and takes the quotient bits in at the
  // bottom, so it holds the quotient once all steps are done.
  always_comb begin
    dsr_ext = {1'b0, dsr_q};
    t1 = {rem_q, dv_q[msd_pkg::WideBits-1]};
    q1 = (t1 >= dsr_ext);
    r1 = q1 ? msd_pkg::NnBits'(t1 - dsr_ext) : t1[msd_pkg::NnBits-1:0];
    t2 = {r1, dv_q[msd_pkg::WideBits-2]};
    q2 = (t2 >= dsr_ext);
    r2 = q2 ? msd_pkg::NnBits'(t2 - dsr_ext) : t2[msd_pkg::NnBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dv_q   <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dv_q  <= {dv_q[msd_pkg::WideBits-3:0], q1, q2};
        rem_q <= r2;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == msd_pkg::DivCntBits'(msd_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dv_q;

endmodule

`default_nettype wire

/* rtl/core/msd_isqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle, floored.
// Depends on msd_pkg.
`default_nettype none

module msd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msd_pkg::WideBits-1:0]  radicand_i,
  output logic                          done_o,
  output logic [msd_pkg::RootBits-1:0]  root_o
);

  logic [msd_pkg::WideBits-1:0]    rad_q;
  logic [msd_pkg::RootBits:0]      rem_q;
  logic [msd_pkg::RootBits-1:0]    root_q;
  logic [msd_pkg::RootCntBits-1:0] cnt_q;
  logic                            busy_q;
  logic                            done_q;

  logic [msd_pkg::RootBits+2:0]    part;
  logic [msd_pkg::RootBits+2:0]    trial;
  logic                            ge;
  logic [msd_pkg::RootBits:0]      rem_d;

  // The remainder never exceeds twice the partial root, so it fits one bit
  // more than the root.
  always_comb begin
    part  = {rem_q, rad_q[msd_pkg::WideBits-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (part >= trial);
    rem_d = ge ? (msd_pkg::RootBits + 1)'(part - trial) :
                 (msd_pkg::RootBits + 1)'(part);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q  <= {rad_q[msd_pkg::WideBits-3:0], 2'b00};
        rem_q  <= rem_d;
        root_q <= {root_q[msd_pkg::RootBits-2:0], ge};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == msd_pkg::RootCntBits'(msd_pkg::RootSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* verif/tb_moving_standard_deviation.sv */
`timescale 1ns / 1ps
// Testbench for moving_standard_deviation: a scoreboard class predicts each
// windowed deviation and checks it against the results of the block.
// Depends on msd_pkg and the msd_in_if / msd_out_if channel interfaces.

module tb_moving_standard_deviation;
  import msd_pkg::*;

  localparam int unsigned SettleCycles = 100;   // longer than one request's work
  localparam int unsigned QuietLimit   = 2000;  // cycles with no handshake at all
  localparam logic [SampleW-1:0] SampleMax = '1;

  // Keeps its own copy of the window and the running sums and queues the
  // deviation that each request should produce.
  class deviation_scoreboard;
    bit [SampleW-1:0] held_samples [MaxWindow];
    bit [AddrBits-1:0] slot;
    bit [LenBits-1:0]  held;
    bit [31:0]         sum;
    bit [55:0]         sum_sq;
    bit [LenBits-1:0]  length;
    bit [DevBits-1:0]  expected_devs [$];
    int unsigned       errors;

    function new();
      foreach (held_samples[i]) held_samples[i] = '0;
      length = LenBits'(LenReset);
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      slot   = '0;
      held   = '0;
      sum    = '0;
      sum_sq = '0;
    endfunction

    function void set_length(bit [LenBits-1:0] value);
      length = value;
      clear_window();
    endfunction

    function int unsigned active_length();
      if (length == 0) return 1;
      if (length > MaxWindow) return MaxWindow;
      return 32'(length);
    endfunction

    function bit [63:0] floor_root(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function void note_request(bit [SampleW-1:0] sample, bit restart);
      int unsigned n;
      int unsigned oldest;
      bit [63:0]   sq;
      bit [63:0]   a;
      bit [63:0]   b;
      bit [63:0]   d;
      bit [63:0]   root;
      n = active_length();
      if (restart) clear_window();
      if (held >= n) begin
        oldest = (slot + MaxWindow - n) % MaxWindow;
        sq = {40'd0, held_samples[oldest]} * {40'd0, held_samples[oldest]};
        sum    -= {8'd0, held_samples[oldest]};
        sum_sq -= sq[55:0];
      end else begin
        held++;
      end
      held_samples[slot] = sample;
      sq = {40'd0, sample} * {40'd0, sample};
      sum    += {8'd0, sample};
      sum_sq += sq[55:0];
      slot++;
      if (held < n) return;
      a = 64'(n) * {8'd0, sum_sq};
      b = {32'd0, sum} * {32'd0, sum};
      d = (a >= b) ? a - b : 64'd0;
      root = floor_root(d / (64'(n) * 64'(n)));
      expected_devs.push_back(root[DevBits-1:0]);
    endfunction

    function void check_result(bit [DevBits-1:0] deviation);
      bit [DevBits-1:0] want;
      if (expected_devs.size() == 0) begin
        $display("[%0t] deviation %0d arrived with none pending", $time, deviation);
        errors++;
        return;
      end
      want = expected_devs.pop_front();
      if (deviation !== want) begin
        $display("[%0t] deviation mismatch: expected %0d, actual %0d",
                 $time, want, deviation);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_devs.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LenBits-1:0] cfg_wdata_i;

  msd_in_if  in_ch ();
  msd_out_if out_ch ();

  deviation_scoreboard sb = new();
  int unsigned sent_count = 0;

  moving_standard_deviation uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_sample(input logic [SampleW-1:0] sample, input logic restart);
    int unsigned gap;
    // Every 48 requests open with a run of back-to-back requests.
    gap = ((sent_count % 48) < 12) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= sample;
    in_ch.restart <= restart;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(sample, restart);
    sent_count++;
  endtask

  // Holds off requests until every queued deviation is back, then waits settle
  // cycles so the block can finish any request that produces no result.
  task automatic drain_results(input int unsigned settle);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LenBits-1:0] value);
    drain_results(SettleCycles);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(value);
  endtask

  function automatic logic [SampleW-1:0] draw_sample(input logic [SampleW-1:0] base);
    case ($urandom_range(0, 3))
      0:       return SampleW'($urandom());
      1:       return SampleW'(base + $urandom_range(0, 255));
      2:       return $urandom_range(0, 1) ? SampleMax : '0;
      default: return SampleW'($urandom() & $urandom());
    endcase
  endfunction

  // Result side: stalls a random number of cycles before each result, with
  // stretches of immediate acceptance.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ((taken % 40) < 10) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_result(out_ch.deviation);
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned       phase_len [8];
    int unsigned       span;
    int unsigned       count;
    logic [SampleW-1:0] base;
    logic              restart;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.restart = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length: a restart on the very first sample, then alternating
    // extremes so the one full window gives a large deviation.
    for (int i = 0; i < 21; i++) begin
      send_sample(i[0] ? '0 : SampleMax, i == 0);
    end

    // Length two with both extremes reaches the largest deviation; a
    // restart in between leaves that sample without a result.
    write_length(2);
    send_sample('0, 1'b0);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMax, 1'b1);
    send_sample('0, 1'b0);

    phase_len = '{1, 0, 3, 256, 2, 511, 21, 0};
    phase_len[7] = $urandom_range(4, 40);
    for (int p = 0; p < 8; p++) begin
      write_length(phase_len[p][LenBits-1:0]);
      span = (phase_len[p] == 0) ? 1 :
             (phase_len[p] > MaxWindow) ? MaxWindow : phase_len[p];
      count = span + ((span >= 200) ? 50 : 36);
      base = SampleW'($urandom());
      for (int k = 0; k < count; k++) begin
        restart = (span >= 200) ? ($urandom_range(0, 399) == 0) :
                                  ($urandom_range(0, 24) == 0);
        send_sample(draw_sample(base), restart);
        if (k == count / 2) drain_results(0);
      end
    end

    drain_results(SettleCycles);
    if (sb.pending() != 0) begin
      $display("[%0t] %0d deviations never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
